@@ hdl/tksd_pkg.sv @@
// ----------------------------------------------------------------------------
// tksd_pkg
// Shared types, key codes and the escape sequence table of the key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tksd_pkg;

  localparam int SEQ_MAX    = 7;   // longest table sequence
  localparam int TABLE_SIZE = 48;

  // key codes
  localparam logic [4:0] KC_ERROR = 5'd0;
  localparam logic [4:0] KC_PLAIN = 5'd1;
  localparam logic [4:0] KC_MOD   = 5'd2;
  localparam logic [4:0] KC_ENTER = 5'd3;
  localparam logic [4:0] KC_TAB   = 5'd4;
  localparam logic [4:0] KC_ESC   = 5'd5;
  localparam logic [4:0] KC_BKSP  = 5'd6;
  localparam logic [4:0] KC_UP    = 5'd7;
  localparam logic [4:0] KC_DOWN  = 5'd8;
  localparam logic [4:0] KC_RIGHT = 5'd9;
  localparam logic [4:0] KC_LEFT  = 5'd10;
  localparam logic [4:0] KC_END   = 5'd11;
  localparam logic [4:0] KC_HOME  = 5'd12;
  localparam logic [4:0] KC_F1    = 5'd13;
  localparam logic [4:0] KC_F2    = 5'd14;
  localparam logic [4:0] KC_F3    = 5'd15;
  localparam logic [4:0] KC_F4    = 5'd16;
  localparam logic [4:0] KC_F5    = 5'd17;
  localparam logic [4:0] KC_F6    = 5'd18;
  localparam logic [4:0] KC_F7    = 5'd19;
  localparam logic [4:0] KC_F8    = 5'd20;
  localparam logic [4:0] KC_F9    = 5'd21;
  localparam logic [4:0] KC_F10   = 5'd22;
  localparam logic [4:0] KC_F11   = 5'd23;
  localparam logic [4:0] KC_F12   = 5'd24;
  localparam logic [4:0] KC_INS   = 5'd25;
  localparam logic [4:0] KC_DEL   = 5'd26;
  localparam logic [4:0] KC_PGUP  = 5'd27;
  localparam logic [4:0] KC_PGDN  = 5'd28;

  // modifiers
  localparam logic [1:0] MOD_NONE = 2'd0;
  localparam logic [1:0] MOD_CTRL = 2'd1;
  localparam logic [1:0] MOD_META = 2'd2;

  localparam logic [6:0] CH_TILDE = 7'h7e;
  localparam logic [6:0] CH_QUERY = 7'h3f;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CTRL_OFS = 7'h40;

  typedef logic [0:SEQ_MAX-1][7:0] seq_bytes_t;

  typedef struct packed {
    logic [4:0] code;
    logic [1:0] modifier;
    logic [2:0] len;
    seq_bytes_t seq;
  } seq_entry_t;

  typedef struct packed {
    logic [4:0] code;
    logic [1:0] modifier;
    logic [6:0] ch;
  } key_event_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // take the input byte into the hold buffer
    logic step;   // resolve the head and emit one event
  } tksd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic can_go;    // head can be resolved now
    logic more;      // another event follows the one resolved now
    logic out_free;  // output register can take an event
  } tksd_status_t;

  // first match wins
  localparam seq_entry_t SEQ_TABLE [TABLE_SIZE] = '{
    '{KC_F1,  MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h31, 8'h3b, 8'h35, 8'h50, 8'h00}},
    '{KC_F2,  MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h31, 8'h3b, 8'h35, 8'h51, 8'h00}},
    '{KC_F3,  MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h31, 8'h3b, 8'h35, 8'h52, 8'h00}},
    '{KC_F4,  MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h31, 8'h3b, 8'h35, 8'h53, 8'h00}},
    '{KC_F5,  MOD_CTRL, 3'd7, '{8'h1b, 8'h5b, 8'h31, 8'h35, 8'h3b, 8'h35, 8'h7e}},
    '{KC_F6,  MOD_CTRL, 3'd7, '{8'h1b, 8'h5b, 8'h31, 8'h37, 8'h3b, 8'h35, 8'h7e}},
    '{KC_F7,  MOD_CTRL, 3'd7, '{8'h1b, 8'h5b, 8'h31, 8'h38, 8'h3b, 8'h35, 8'h7e}},
    '{KC_F8,  MOD_CTRL, 3'd7, '{8'h1b, 8'h5b, 8'h31, 8'h39, 8'h3b, 8'h35, 8'h7e}},
    '{KC_F9,  MOD_CTRL, 3'd7, '{8'h1b, 8'h5b, 8'h32, 8'h30, 8'h3b, 8'h35, 8'h7e}},
    '{KC_F10, MOD_CTRL, 3'd7, '{8'h1b, 8'h5b, 8'h32, 8'h31, 8'h3b, 8'h35, 8'h7e}},
    '{KC_F11, MOD_CTRL, 3'd7, '{8'h1b, 8'h5b, 8'h32, 8'h33, 8'h3b, 8'h35, 8'h7e}},
    '{KC_F12, MOD_CTRL, 3'd7, '{8'h1b, 8'h5b, 8'h32, 8'h34, 8'h3b, 8'h35, 8'h7e}},
    '{KC_UP,    MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h31, 8'h3b, 8'h35, 8'h41, 8'h00}},
    '{KC_DOWN,  MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h31, 8'h3b, 8'h35, 8'h42, 8'h00}},
    '{KC_RIGHT, MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h31, 8'h3b, 8'h35, 8'h43, 8'h00}},
    '{KC_LEFT,  MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h31, 8'h3b, 8'h35, 8'h44, 8'h00}},
    '{KC_END,   MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h31, 8'h3b, 8'h35, 8'h46, 8'h00}},
    '{KC_HOME,  MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h31, 8'h3b, 8'h35, 8'h48, 8'h00}},
    '{KC_INS,   MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h32, 8'h3b, 8'h35, 8'h7e, 8'h00}},
    '{KC_DEL,   MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h33, 8'h3b, 8'h35, 8'h7e, 8'h00}},
    '{KC_PGUP,  MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h35, 8'h3b, 8'h35, 8'h7e, 8'h00}},
    '{KC_PGDN,  MOD_CTRL, 3'd6, '{8'h1b, 8'h5b, 8'h36, 8'h3b, 8'h35, 8'h7e, 8'h00}},
    '{KC_F5,  MOD_NONE, 3'd5, '{8'h1b, 8'h5b, 8'h31, 8'h35, 8'h7e, 8'h00, 8'h00}},
    '{KC_F6,  MOD_NONE, 3'd5, '{8'h1b, 8'h5b, 8'h31, 8'h37, 8'h7e, 8'h00, 8'h00}},
    '{KC_F7,  MOD_NONE, 3'd5, '{8'h1b, 8'h5b, 8'h31, 8'h38, 8'h7e, 8'h00, 8'h00}},
    '{KC_F8,  MOD_NONE, 3'd5, '{8'h1b, 8'h5b, 8'h31, 8'h39, 8'h7e, 8'h00, 8'h00}},
    '{KC_F9,  MOD_NONE, 3'd5, '{8'h1b, 8'h5b, 8'h32, 8'h30, 8'h7e, 8'h00, 8'h00}},
    '{KC_F10, MOD_NONE, 3'd5, '{8'h1b, 8'h5b, 8'h32, 8'h31, 8'h7e, 8'h00, 8'h00}},
    '{KC_F11, MOD_NONE, 3'd5, '{8'h1b, 8'h5b, 8'h32, 8'h33, 8'h7e, 8'h00, 8'h00}},
    '{KC_F12, MOD_NONE, 3'd5, '{8'h1b, 8'h5b, 8'h32, 8'h34, 8'h7e, 8'h00, 8'h00}},
    '{KC_INS,   MOD_NONE, 3'd4, '{8'h1b, 8'h5b, 8'h32, 8'h7e, 8'h00, 8'h00, 8'h00}},
    '{KC_DEL,   MOD_NONE, 3'd4, '{8'h1b, 8'h5b, 8'h33, 8'h7e, 8'h00, 8'h00, 8'h00}},
    '{KC_PGUP,  MOD_NONE, 3'd4, '{8'h1b, 8'h5b, 8'h35, 8'h7e, 8'h00, 8'h00, 8'h00}},
    '{KC_PGDN,  MOD_NONE, 3'd4, '{8'h1b, 8'h5b, 8'h36, 8'h7e, 8'h00, 8'h00, 8'h00}},
    '{KC_UP,    MOD_NONE, 3'd3, '{8'h1b, 8'h5b, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_DOWN,  MOD_NONE, 3'd3, '{8'h1b, 8'h5b, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_RIGHT, MOD_NONE, 3'd3, '{8'h1b, 8'h5b, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_LEFT,  MOD_NONE, 3'd3, '{8'h1b, 8'h5b, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_END,   MOD_NONE, 3'd3, '{8'h1b, 8'h5b, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_HOME,  MOD_NONE, 3'd3, '{8'h1b, 8'h5b, 8'h48, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_F1,    MOD_NONE, 3'd3, '{8'h1b, 8'h4f, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_F2,    MOD_NONE, 3'd3, '{8'h1b, 8'h4f, 8'h51, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_F3,    MOD_NONE, 3'd3, '{8'h1b, 8'h4f, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_F4,    MOD_NONE, 3'd3, '{8'h1b, 8'h4f, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_ENTER, MOD_NONE, 3'd1, '{8'h0d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_ESC,   MOD_NONE, 3'd1, '{8'h1b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_TAB,   MOD_NONE, 3'd1, '{8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{KC_BKSP,  MOD_NONE, 3'd1, '{8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}}
  };

  function automatic logic is_plain(input logic [7:0] b);
    return (b >= 8'h20) && (b <= 8'h7e);
  endfunction

  function automatic logic is_ctrl(input logic [7:0] b);
    return (b < 8'h1b) && (b != 8'h09) && (b != 8'h0a) && (b != 8'h0d);
  endfunction

  // byte compare of the window against one entry, over its length only
  function automatic logic seq_equal(input seq_entry_t e, input seq_bytes_t win);
    logic eq;
    eq = 1'b1;
    for (int j = 0; j < SEQ_MAX; j++) begin
      if ((3'(j) < e.len) && (win[j] != e.seq[j])) begin
        eq = 1'b0;
      end
    end
    return eq;
  endfunction

endpackage

`default_nettype wire

@@ hdl/tksd_ctrl.sv @@
// ----------------------------------------------------------------------------
// tksd_ctrl
// Sequencer: takes one byte, then steps out events until none is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tksd_ctrl
  import tksd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  input  wire tksd_status_t status,
  output      tksd_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status.can_go) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.step = 1'b1;
          if (!status.more) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tksd_datapath.sv @@
// ----------------------------------------------------------------------------
// tksd_datapath
// Hold buffer, head resolver against the sequence table, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tksd_datapath
  import tksd_pkg::*;
#(
  parameter int HOLD_DEPTH = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire tksd_cmd_t    cmd,
  output      tksd_status_t status,
  input  wire logic [7:0]   s_tdata,
  input  wire logic         s_tlast,
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  output      logic [15:0]  m_tdata,
  output      logic         m_tlast
);

  localparam int CW = $clog2(HOLD_DEPTH + 1);

  logic [HOLD_DEPTH-1:0][7:0]         held;
  logic [CW-1:0]                      count;
  logic                               chunk_end;
  logic [HOLD_DEPTH+SEQ_MAX-1:0][7:0] ext;
  logic [HOLD_DEPTH+SEQ_MAX-1:0][7:0] ext_sh;
  seq_bytes_t                         win;
  logic [7:0]                         head;
  logic [7:0]                         head_nx;
  logic [2:0]                         used;
  logic [CW-1:0]                      count_nx;
  logic                               hit;
  seq_entry_t                         entry;
  key_event_t                         ev;
  key_event_t                         out_ev;
  logic                               out_last;
  logic                               more;

  assign head = held[0];

  always_comb begin
    for (int j = 0; j < SEQ_MAX; j++) begin
      win[j] = held[j];
    end
  end

  // first matching table entry that fits in the held bytes
  always_comb begin
    hit   = 1'b0;
    entry = SEQ_TABLE[0];
    for (int t = 0; t < TABLE_SIZE; t++) begin
      if (!hit && (CW'(SEQ_TABLE[t].len) <= count) && seq_equal(SEQ_TABLE[t], win)) begin
        hit   = 1'b1;
        entry = SEQ_TABLE[t];
      end
    end
  end

  always_comb begin
    if (is_plain(head)) begin
      ev   = '{KC_PLAIN, MOD_NONE, head[6:0]};
      used = 3'd1;
    end else if (is_ctrl(head)) begin
      ev   = '{KC_MOD, MOD_CTRL, (head == 8'h00) ? CH_SPACE : head[6:0] + CTRL_OFS};
      used = 3'd1;
    end else if (hit) begin
      if ((entry.code == KC_ESC) && (count >= CW'(2)) && is_plain(held[1])) begin
        ev   = '{KC_MOD, MOD_META, held[1][6:0]};
        used = 3'd2;
      end else begin
        ev   = '{entry.code, entry.modifier, CH_TILDE};
        used = entry.len;
      end
    end else begin
      ev   = '{KC_ERROR, MOD_NONE, CH_QUERY};
      used = 3'd1;
    end
  end

  // buffer after dropping the consumed bytes
  assign ext      = {{SEQ_MAX{8'h00}}, held};
  assign ext_sh   = ext >> {used, 3'b000};
  assign head_nx  = ext_sh[0];
  assign count_nx = count - CW'(used);

  assign more = (count_nx != '0) &&
                (chunk_end || is_plain(head_nx) || is_ctrl(head_nx) ||
                 (count_nx >= CW'(SEQ_MAX)));

  assign status.can_go   = (count != '0) &&
                           (chunk_end || is_plain(head) || is_ctrl(head) ||
                            (count >= CW'(SEQ_MAX)));
  assign status.more     = more;
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load && (count < CW'(HOLD_DEPTH))) begin
      count <= count + CW'(1);
    end else if (cmd.step) begin
      count <= count_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chunk_end <= s_tlast;
      for (int i = 0; i < HOLD_DEPTH; i++) begin
        if (count == CW'(i)) begin
          held[i] <= s_tdata;
        end
      end
    end else if (cmd.step) begin
      held <= ext_sh[HOLD_DEPTH-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_ev   <= ev;
      out_last <= !more;
    end
  end

  assign m_tdata = {2'b00, out_ev.ch, out_ev.modifier, out_ev.code};
  assign m_tlast = out_last;

endmodule

`default_nettype wire

@@ hdl/terminal_key_sequence_decoder.sv @@
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder
// Raw terminal bytes in, key events out (plain, CTRL, META, escape keys).
// ----------------------------------------------------------------------------
//
//   channel  dir  tdata fields (low bit up)                    tlast
//   s_*      in   data_byte[7:0]                               chunk_end
//   m_*      out  key_code[4:0] modifier[6:5] char_value[13:7]  last_of_run
//                 pad[15:14] = 0
//
// Flow: a load takes the byte into the hold buffer, then the sequencer
//   resolves one event per cycle from the buffer head while the output
//   register can take it. At most 7 bytes are held after a load, so one
//   byte releases at most 7 events. A byte with no event gets the load,
//   then the check that finds nothing ready.
// Reset: rst (sync, active high) empties the hold buffer and the output.
// Stalls: m_tready low holds the sequencer while the output register is full;
//   s_tready is high only while idle, even with an event still waiting there.
//
`default_nettype none

module terminal_key_sequence_decoder
  import tksd_pkg::*;
#(
  parameter int HOLD_DEPTH = 8   // held bytes, 7..16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
  input  wire logic        s_tlast,   // chunk_end
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [15:0] m_tdata,   // key_code[4:0], modifier[6:5], char_value[13:7]
  output      logic        m_tlast    // last_of_run
);

  tksd_cmd_t    cmd;
  tksd_status_t status;

  // sequencer: idle / run
  tksd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // hold buffer, table match and output register
  tksd_datapath #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the terminal key sequence decoder: a directed table
// of corner bytes, then random key sequences, noise and cut-off chunks, all
// scored item by item against the directed events or a behavioural decoder kept in this file.
// ----------------------------------------------------------------------------

module testbench
  import tksd_pkg::*;
();

  localparam int HOLD_DEPTH  = 8;
  localparam int MAX_RUN     = 8;     // upper bound on events one byte can release
  localparam int QUIET_LIMIT = 4000;  // cycles with no item moving on either side
  localparam int LONG_HOLD   = 300;   // receiver hold-off to back the block up

  localparam logic [7:0] BYTE_ESC = 8'h1b;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_CR  = 8'h0d;

  typedef struct packed {
    logic [4:0] code;
    logic [1:0] modifier;
    logic [6:0] ch;
    logic       last;
  } key_result_t;

  // escape table, first byte in the top bits of seq
  typedef struct packed {
    logic [4:0]      code;
    logic [1:0]      modifier;
    logic [2:0]      len;
    logic [0:6][7:0] seq;
  } key_seq_t;

  localparam key_seq_t KEY_SEQS [TABLE_SIZE] = '{
    '{KC_F1,    MOD_CTRL, 3'd6, 56'h1b5b313b355000},
    '{KC_F2,    MOD_CTRL, 3'd6, 56'h1b5b313b355100},
    '{KC_F3,    MOD_CTRL, 3'd6, 56'h1b5b313b355200},
    '{KC_F4,    MOD_CTRL, 3'd6, 56'h1b5b313b355300},
    '{KC_F5,    MOD_CTRL, 3'd7, 56'h1b5b31353b357e},
    '{KC_F6,    MOD_CTRL, 3'd7, 56'h1b5b31373b357e},
    '{KC_F7,    MOD_CTRL, 3'd7, 56'h1b5b31383b357e},
    '{KC_F8,    MOD_CTRL, 3'd7, 56'h1b5b31393b357e},
    '{KC_F9,    MOD_CTRL, 3'd7, 56'h1b5b32303b357e},
    '{KC_F10,   MOD_CTRL, 3'd7, 56'h1b5b32313b357e},
    '{KC_F11,   MOD_CTRL, 3'd7, 56'h1b5b32333b357e},
    '{KC_F12,   MOD_CTRL, 3'd7, 56'h1b5b32343b357e},
    '{KC_UP,    MOD_CTRL, 3'd6, 56'h1b5b313b354100},
    '{KC_DOWN,  MOD_CTRL, 3'd6, 56'h1b5b313b354200},
    '{KC_RIGHT, MOD_CTRL, 3'd6, 56'h1b5b313b354300},
    '{KC_LEFT,  MOD_CTRL, 3'd6, 56'h1b5b313b354400},
    '{KC_END,   MOD_CTRL, 3'd6, 56'h1b5b313b354600},
    '{KC_HOME,  MOD_CTRL, 3'd6, 56'h1b5b313b354800},
    '{KC_INS,   MOD_CTRL, 3'd6, 56'h1b5b323b357e00},
    '{KC_DEL,   MOD_CTRL, 3'd6, 56'h1b5b333b357e00},
    '{KC_PGUP,  MOD_CTRL, 3'd6, 56'h1b5b353b357e00},
    '{KC_PGDN,  MOD_CTRL, 3'd6, 56'h1b5b363b357e00},
    '{KC_F5,    MOD_NONE, 3'd5, 56'h1b5b31357e0000},
    '{KC_F6,    MOD_NONE, 3'd5, 56'h1b5b31377e0000},
    '{KC_F7,    MOD_NONE, 3'd5, 56'h1b5b31387e0000},
    '{KC_F8,    MOD_NONE, 3'd5, 56'h1b5b31397e0000},
    '{KC_F9,    MOD_NONE, 3'd5, 56'h1b5b32307e0000},
    '{KC_F10,   MOD_NONE, 3'd5, 56'h1b5b32317e0000},
    '{KC_F11,   MOD_NONE, 3'd5, 56'h1b5b32337e0000},
    '{KC_F12,   MOD_NONE, 3'd5, 56'h1b5b32347e0000},
    '{KC_INS,   MOD_NONE, 3'd4, 56'h1b5b327e000000},
    '{KC_DEL,   MOD_NONE, 3'd4, 56'h1b5b337e000000},
    '{KC_PGUP,  MOD_NONE, 3'd4, 56'h1b5b357e000000},
    '{KC_PGDN,  MOD_NONE, 3'd4, 56'h1b5b367e000000},
    '{KC_UP,    MOD_NONE, 3'd3, 56'h1b5b4100000000},
    '{KC_DOWN,  MOD_NONE, 3'd3, 56'h1b5b4200000000},
    '{KC_RIGHT, MOD_NONE, 3'd3, 56'h1b5b4300000000},
    '{KC_LEFT,  MOD_NONE, 3'd3, 56'h1b5b4400000000},
    '{KC_END,   MOD_NONE, 3'd3, 56'h1b5b4600000000},
    '{KC_HOME,  MOD_NONE, 3'd3, 56'h1b5b4800000000},
    '{KC_F1,    MOD_NONE, 3'd3, 56'h1b4f5000000000},
    '{KC_F2,    MOD_NONE, 3'd3, 56'h1b4f5100000000},
    '{KC_F3,    MOD_NONE, 3'd3, 56'h1b4f5200000000},
    '{KC_F4,    MOD_NONE, 3'd3, 56'h1b4f5300000000},
    '{KC_ENTER, MOD_NONE, 3'd1, 56'h0d000000000000},
    '{KC_ESC,   MOD_NONE, 3'd1, 56'h1b000000000000},
    '{KC_TAB,   MOD_NONE, 3'd1, 56'h09000000000000},
    '{KC_BKSP,  MOD_NONE, 3'd1, 56'h7f000000000000}
  };

  // directed rows; 'typed' rows carry their single event, the rest go to the decoder
  typedef struct packed {
    logic [7:0] data;
    logic       chunk_end;
    logic       typed;
    logic [4:0] code;
    logic [1:0] modifier;
    logic [6:0] ch;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 28;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'h20, 1'b0, 1'b1, KC_PLAIN, MOD_NONE, 7'h20},  // lowest plain, straight after reset
    '{8'h7e, 1'b0, 1'b1, KC_PLAIN, MOD_NONE, 7'h7e},  // highest plain
    '{8'h00, 1'b0, 1'b1, KC_MOD,   MOD_CTRL, CH_SPACE},
    '{8'h1a, 1'b0, 1'b1, KC_MOD,   MOD_CTRL, 7'h5a},
    '{8'h01, 1'b0, 1'b1, KC_MOD,   MOD_CTRL, 7'h41},
    '{8'hff, 1'b1, 1'b1, KC_ERROR, MOD_NONE, CH_QUERY},
    '{8'h80, 1'b1, 1'b1, KC_ERROR, MOD_NONE, CH_QUERY},
    '{BYTE_LF, 1'b1, 1'b1, KC_ERROR, MOD_NONE, CH_QUERY},
    '{8'h1c, 1'b1, 1'b1, KC_ERROR, MOD_NONE, CH_QUERY},
    '{BYTE_CR, 1'b1, 1'b1, KC_ENTER, MOD_NONE, CH_TILDE},
    '{BYTE_TAB, 1'b1, 1'b1, KC_TAB, MOD_NONE, CH_TILDE},
    '{8'h7f, 1'b1, 1'b1, KC_BKSP,  MOD_NONE, CH_TILDE},
    '{BYTE_ESC, 1'b1, 1'b1, KC_ESC, MOD_NONE, CH_TILDE},  // lone escape at chunk end
    // escape then a plain byte: meta key
    '{BYTE_ESC, 1'b0, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    '{8'h61, 1'b1, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    // SS3 form of F4
    '{BYTE_ESC, 1'b0, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    '{8'h4f, 1'b0, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    '{8'h53, 1'b1, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    // longest sequence, resolved by fill level with no chunk end
    '{BYTE_ESC, 1'b0, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    '{8'h5b, 1'b0, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    '{8'h32, 1'b0, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    '{8'h34, 1'b0, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    '{8'h3b, 1'b0, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    '{8'h35, 1'b0, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    '{8'h7e, 1'b0, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    // sequence cut off by the chunk end: replayed as meta '[' then '1'
    '{BYTE_ESC, 1'b0, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    '{8'h5b, 1'b0, 1'b0, KC_ERROR, MOD_NONE, 7'h00},
    '{8'h31, 1'b1, 1'b0, KC_ERROR, MOD_NONE, 7'h00}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;  // data_byte[7:0]
  logic        s_tlast  = 1'b0;   // chunk_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // key_code[4:0], modifier[6:5], char_value[13:7]
  logic        m_tlast;           // last_of_run

  // the row on offer, travelling with s_tdata
  logic        row_typed = 1'b0;
  key_result_t row_key   = '0;

  logic [7:0]  hold_buf [HOLD_DEPTH];
  int          hold_n = 0;
  key_result_t fresh_keys [$];
  key_result_t pending_keys [$];

  int unsigned fail_count   = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  int          hold_cycles  = 0;
  bit          idle_on      = 1'b1;

  always #5 clk = ~clk;

  terminal_key_sequence_decoder #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // --------------------------------------------------------------------------
  // decoder model
  // --------------------------------------------------------------------------
  function automatic logic printable(input logic [7:0] b);
    return (b >= 8'h20) && (b <= 8'h7e);
  endfunction

  function automatic logic ctrl_key(input logic [7:0] b);
    return (b < BYTE_ESC) && (b != BYTE_TAB) && (b != BYTE_LF) && (b != BYTE_CR);
  endfunction

  // event for the head of the hold buffer; returns bytes consumed
  function automatic int match_head(input int avail, output key_result_t ev);
    logic [7:0] h0;
    logic       hit;
    int         used;
    h0   = hold_buf[0];
    ev   = '0;
    used = 1;
    hit  = 1'b0;
    if (printable(h0)) begin
      ev.code     = KC_PLAIN;
      ev.modifier = MOD_NONE;
      ev.ch       = h0[6:0];
    end else if (ctrl_key(h0)) begin
      ev.code     = KC_MOD;
      ev.modifier = MOD_CTRL;
      ev.ch       = (h0 == 8'h00) ? CH_SPACE : h0[6:0] + CTRL_OFS;
    end else begin
      ev.code     = KC_ERROR;
      ev.modifier = MOD_NONE;
      ev.ch       = CH_QUERY;
      for (int i = 0; i < TABLE_SIZE && !hit; i++) begin
        if (int'(KEY_SEQS[i].len) <= avail) begin
          hit = 1'b1;
          for (int j = 0; j < int'(KEY_SEQS[i].len); j++) begin
            if (hold_buf[j] != KEY_SEQS[i].seq[j]) hit = 1'b0;
          end
          if (hit) begin
            // a lone escape swallows a following plain byte as meta
            if (KEY_SEQS[i].code == KC_ESC && avail >= 2 && printable(hold_buf[1])) begin
              ev.code     = KC_MOD;
              ev.modifier = MOD_META;
              ev.ch       = hold_buf[1][6:0];
              used        = 2;
            end else begin
              ev.code     = KEY_SEQS[i].code;
              ev.modifier = KEY_SEQS[i].modifier;
              ev.ch       = CH_TILDE;
              used        = int'(KEY_SEQS[i].len);
            end
          end
        end
      end
    end
    return used;
  endfunction

  // take one byte, leave the events it releases in fresh_keys
  function automatic void decode_byte(input logic [7:0] b, input logic chunk_end);
    key_result_t ev;
    int          used;
    logic [7:0]  h0;
    fresh_keys.delete();
    if (hold_n < HOLD_DEPTH) begin
      hold_buf[hold_n] = b;
      hold_n++;
    end
    while (hold_n > 0 && fresh_keys.size() < MAX_RUN) begin
      h0 = hold_buf[0];
      // a sequence head waits for the chunk end or a full window
      if (!chunk_end && !printable(h0) && !ctrl_key(h0) && hold_n < SEQ_MAX) break;
      used = match_head(hold_n, ev);
      if (used > hold_n) used = hold_n;
      for (int k = 0; k < hold_n - used; k++) hold_buf[k] = hold_buf[k + used];
      hold_n -= used;
      fresh_keys.push_back(ev);
    end
    if (fresh_keys.size() > 0) begin
      ev      = fresh_keys.pop_back();
      ev.last = 1'b1;
      fresh_keys.push_back(ev);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // scoreboard: results first, then the new byte, all on sampled values
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    key_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_keys.size() == 0) begin
          $error("key event with none pending: tdata %h tlast %b", m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = pending_keys.pop_front();
          check_field("key_code", 32'(want.code), 32'(m_tdata[4:0]));
          check_field("modifier", 32'(want.modifier), 32'(m_tdata[6:5]));
          check_field("char_value", 32'(want.ch), 32'(m_tdata[13:7]));
          check_field("tdata pad", 0, 32'(m_tdata[15:14]));
          check_field("last_of_run", 32'(want.last), 32'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tlast);
        if (row_typed) begin
          pending_keys.push_back(row_key);
        end else begin
          foreach (fresh_keys[k]) pending_keys.push_back(fresh_keys[k]);
        end
      end
    end
  end

  // watchdog: nothing moving on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stall per event, plus one long hold-off on request
  initial begin : event_sink
    int stall;
    forever begin
      @(negedge clk);
      stall       = hold_cycles + (idle_on ? $urandom_range(0, 9) : 0);
      hold_cycles = 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic chunk_end, input logic typed,
                           input logic [4:0] code, input logic [1:0] modifier,
                           input logic [6:0] ch);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= b;
    s_tlast   <= chunk_end;
    row_typed <= typed;
    row_key   <= '{code, modifier, ch, 1'b1};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // mostly well-formed key sequences, some cut short or corrupted, some noise
  task automatic send_token();
    int         kind;
    int         idx;
    int         n;
    logic [7:0] seq_b [SEQ_MAX];
    logic       ends;
    kind = $urandom_range(0, 99);
    n    = 1;
    if (kind < 45) begin
      idx = $urandom_range(0, TABLE_SIZE - 1);
      n   = int'(KEY_SEQS[idx].len);
      for (int k = 0; k < SEQ_MAX; k++) seq_b[k] = KEY_SEQS[idx].seq[k];
      if (n > 1 && $urandom_range(0, 6) == 0) n = $urandom_range(1, n - 1);
      if ($urandom_range(0, 9) == 0) seq_b[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
    end else if (kind < 60) begin
      seq_b[0] = BYTE_ESC;
      seq_b[1] = 8'($urandom_range(8'h20, 8'h7e));
      n        = 2;
    end else if (kind < 75) begin
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) seq_b[k] = 8'($urandom_range(8'h20, 8'h7e));
    end else if (kind < 85) begin
      seq_b[0] = 8'($urandom_range(0, 8'h1a));
    end else begin
      seq_b[0] = 8'($urandom_range(0, 255));
    end
    for (int k = 0; k < n; k++) begin
      ends = (k == n - 1) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 24) == 0);
      send_byte(seq_b[k], ends, 1'b0, KC_ERROR, MOD_NONE, 7'h00);
    end
  endtask

  // stop offering and let every pending event come out
  task automatic wait_for_events(input int settle);
    s_tvalid <= 1'b0;
    while (pending_keys.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned next_toggle;
    bit          held_off;
    bit          paused;
    next_toggle = 40;
    held_off    = 1'b0;
    paused      = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_byte(DIRECTED[r].data, DIRECTED[r].chunk_end, DIRECTED[r].typed,
                DIRECTED[r].code, DIRECTED[r].modifier, DIRECTED[r].ch);
    end
    wait_for_events(12);

    while (items_sent < 430) begin
      // every 40 items, pick at random between stretches with idle gaps and idle-free ones
      if (items_sent >= next_toggle) begin
        idle_on     = ($urandom_range(0, 3) != 0);
        next_toggle = next_toggle + 40;
      end
      // back the block up: receiver holds off while bytes keep coming
      if (!held_off && items_sent >= 150) begin
        hold_cycles = LONG_HOLD;
        held_off    = 1'b1;
      end
      if (!paused && items_sent >= 290) begin
        wait_for_events(12);
        paused = 1'b1;
      end
      send_token();
    end
    // flush whatever is still held
    send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, KC_ERROR, MOD_NONE, 7'h00);
    wait_for_events(20);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ terminal_key_sequence_decoder.f @@
hdl/tksd_pkg.sv
hdl/tksd_ctrl.sv
hdl/tksd_datapath.sv
hdl/terminal_key_sequence_decoder.sv
tb/testbench.sv
